// ===== hdl/hfc_pkg.sv =====
// Shared types, constants and palette function for the heatmap false-color core.
package hfc_pkg;

    localparam int PAL_SIZE  = 1024;
    localparam int PAL_BITS  = $clog2(PAL_SIZE);
    localparam int CNT_BITS  = $clog2(PAL_BITS + 1);

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_MEASURE  = 2'd1,
        OP_COLORIZE = 2'd2,
        OP_UNUSED   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic t_rgb palette_color(input logic [PAL_BITS-1:0] k);
        t_rgb       c;
        logic [7:0] lo;
        lo = k[7:0];
        case (k[9:8])
            2'd0: begin
                c.red = 8'd0;   c.green = lo;     c.blue = 8'd255;
            end
            2'd1: begin
                c.red = 8'd0;   c.green = 8'd255; c.blue = ~lo;
            end
            2'd2: begin
                c.red = lo;     c.green = 8'd255; c.blue = 8'd0;
            end
            default: begin
                c.red = 8'd255; c.green = ~lo;    c.blue = 8'd0;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/hfc_divider.sv =====
// Radix-2 restoring divider producing the palette index one bit per cycle.
module hfc_divider
    import hfc_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_dividend,
    input  logic [SAMPLE_BITS-1:0] i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [PAL_BITS-1:0]    o_quotient
);

    logic [SAMPLE_BITS-1:0] r_rem,     n_rem;
    logic [SAMPLE_BITS-1:0] r_div;
    logic [PAL_BITS-1:0]    r_quo,     n_quo;
    logic [CNT_BITS-1:0]    r_count;
    logic                   r_busy;
    logic                   r_done;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS:0]   trial;

    always_comb begin
        shifted = {r_rem, 1'b0};
        trial   = shifted - {1'b0, r_div};
        if (!trial[SAMPLE_BITS]) begin
            n_rem = trial[SAMPLE_BITS-1:0];
            n_quo = {r_quo[PAL_BITS-2:0], 1'b1};
        end else begin
            n_rem = shifted[SAMPLE_BITS-1:0];
            n_quo = {r_quo[PAL_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_count <= CNT_BITS'(PAL_BITS);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/heatmap_false_color_core.sv =====
// Top level of the heatmap false-color core: range tracking, sequencer and output register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_opcode, i_sample
//  out     | output    | o_out_valid/i_out_stall | o_red, o_green, o_blue, o_palette_index
//
// Clear and measure update the range when taken. Colorize reaches the output register in steps:
// the sample is taken, difference and span are formed, the divider forms the quotient bit by bit,
// the quotient is latched, and the index is mapped to a color; the output stage waits while stalled.
// Empty range, samples below minimum and samples at or above maximum skip the divider.
// Reset is synchronous, active low; the range returns to empty.
// A stalled result holds the output register; the next item is taken meanwhile.
module heatmap_false_color_core
    import hfc_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue,
    output logic [PAL_BITS-1:0]           o_palette_index
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    localparam logic signed [SAMPLE_BITS-1:0] MinReset = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MaxReset = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_state                          r_state;
    logic signed [SAMPLE_BITS-1:0]   r_min;
    logic signed [SAMPLE_BITS-1:0]   r_max;
    logic signed [SAMPLE_BITS-1:0]   r_sample;
    logic [PAL_BITS-1:0]             r_k;
    logic                            r_out_valid;
    logic [7:0]                      r_red, r_green, r_blue;
    logic [PAL_BITS-1:0]             r_index;

    logic                            in_xfer;
    logic                            out_free;
    logic                            div_start;
    logic                            div_busy;
    logic                            div_done;
    logic [PAL_BITS-1:0]             div_quo;
    logic [SAMPLE_BITS:0]            diff_full;
    logic [SAMPLE_BITS:0]            span_full;
    logic                            range_empty;
    logic                            below_min;
    logic                            at_max;
    t_rgb                            pix;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign diff_full = {r_sample[SAMPLE_BITS-1], r_sample} - {r_min[SAMPLE_BITS-1], r_min};
    assign span_full = {r_max[SAMPLE_BITS-1], r_max} - {r_min[SAMPLE_BITS-1], r_min};
    assign range_empty = r_max <= r_min;
    assign below_min   = r_sample < r_min;
    assign at_max      = r_sample >= r_max;
    assign div_start   = (r_state == S_PREP) && !range_empty && !below_min && !at_max;
    assign pix         = palette_color(r_k);

    hfc_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff_full[SAMPLE_BITS-1:0]),
        .i_divisor  (span_full[SAMPLE_BITS-1:0]),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= MinReset;
            r_max       <= MaxReset;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_min <= MinReset;
                                r_max <= MaxReset;
                            end
                            OP_MEASURE: begin
                                if (i_sample > r_max) begin
                                    r_max <= i_sample;
                                end
                                if (i_sample < r_min) begin
                                    r_min <= i_sample;
                                end
                            end
                            OP_COLORIZE: begin
                                r_sample <= i_sample;
                                r_state  <= S_PREP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    if (range_empty || below_min) begin
                        r_k     <= '0;
                        r_state <= S_OUT;
                    end else if (at_max) begin
                        r_k     <= PAL_BITS'(PAL_SIZE - 1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_k     <= div_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_red       <= pix.red;
                        r_green     <= pix.green;
                        r_blue      <= pix.blue;
                        r_index     <= r_k;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_palette_index = r_index;

    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider result outside divide state");

    a_colorize_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_opcode == OP_COLORIZE) |=> r_state == S_PREP)
        else $error("colorize transfer did not enter prep");

    a_measure_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_opcode == OP_MEASURE) |=> r_min <= r_max)
        else $error("range inverted after measure");

endmodule

// ===== tb/tb_heatmap_false_color_core.sv =====
// Self-checking testbench of the heatmap false-color core: range tracking and colorize pixels.
module tb_heatmap_false_color_core;
    timeunit 1ns;
    timeprecision 1ps;
    import hfc_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 17;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] index;
    } t_pixel;

    class pixel_scoreboard;
        logic signed [31:0] range_lo;
        logic signed [31:0] range_hi;
        t_pixel             pending_q[$];
        int                 errors;
        int                 pixels_checked;
        int                 measures;
        int                 clears;
        int                 ignored;

        function new();
            clear_range();
        endfunction

        function void clear_range();
            range_lo = 32'sh7FFF_FFFF;
            range_hi = 32'sh8000_0000;
        endfunction

        function logic [9:0] index_of(logic signed [31:0] v);
            longint diff;
            longint span;
            longint quo;
            if (range_hi <= range_lo || v < range_lo) return '0;
            diff = longint'(v) - longint'(range_lo);
            span = longint'(range_hi) - longint'(range_lo);
            quo  = (diff * 1024) / span;
            if (quo > 1023) quo = 1023;
            return quo[9:0];
        endfunction

        function t_pixel color_of(logic [9:0] k);
            t_pixel     px;
            logic [7:0] step;
            step     = k[7:0];
            px.index = k;
            case (k[9:8])
                2'd0: begin
                    px.red = 8'd0;   px.green = step;           px.blue = 8'd255;
                end
                2'd1: begin
                    px.red = 8'd0;   px.green = 8'd255;         px.blue = 8'd255 - step;
                end
                2'd2: begin
                    px.red = step;   px.green = 8'd255;         px.blue = 8'd0;
                end
                default: begin
                    px.red = 8'd255; px.green = 8'd255 - step;  px.blue = 8'd0;
                end
            endcase
            return px;
        endfunction

        function void note_input(logic [1:0] op, logic signed [31:0] s);
            case (op)
                OP_CLEAR: begin
                    clear_range();
                    clears++;
                end
                OP_MEASURE: begin
                    if (s > range_hi) range_hi = s;
                    if (s < range_lo) range_lo = s;
                    measures++;
                end
                OP_COLORIZE: pending_q.push_back(color_of(index_of(s)));
                default: ignored++;
            endcase
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [9:0] k);
            t_pixel want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected pixel: expected none, actual r=%0d g=%0d b=%0d k=%0d",
                         $time, r, g, b, k);
                return;
            end
            want = pending_q.pop_front();
            pixels_checked++;
            if ($isunknown({r, g, b, k})) begin
                errors++;
                $display("%0t ns: unknown bits: expected k=%0d, actual r=%h g=%h b=%h k=%h",
                         $time, want.index, r, g, b, k);
                return;
            end
            compare_field("red", want.red, r);
            compare_field("green", want.green, g);
            compare_field("blue", want.blue, b);
            compare_field("palette_index", want.index, k);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [1:0]              i_opcode;
    logic signed [31:0]      i_sample;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [7:0]              o_red;
    logic [7:0]              o_green;
    logic [7:0]              o_blue;
    logic [PAL_BITS-1:0]     o_palette_index;

    pixel_scoreboard sb = new();
    bit              in_idle_en;
    bit              out_idle_en;
    bit              hold_req;
    int              work_items;
    int              edge_k[7] = '{255, 256, 511, 512, 767, 768, 1023};

    heatmap_false_color_core #(
        .SAMPLE_BITS(32)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_palette_index(o_palette_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("** heatmap_false_color_core: FAILED **");
        $finish;
    end

    // Receiver: random stall, plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= out_idle_en && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_pixel(o_red, o_green, o_blue, o_palette_index);
        end
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [1:0] op, input logic [31:0] s);
        if (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(op, s);
        if (op != OP_UNUSED) work_items++;
        @(negedge i_clk);
    endtask

    task automatic measure_value(input int shape, input logic [31:0] base,
                                 output logic [31:0] s);
        case (shape)
            0:       s = $urandom;
            1:       s = base + $urandom_range(0, 2047);
            2:       s = base + $urandom_range(0, 1 << 20);
            default: s = base;
        endcase
    endtask

    task automatic colorize_value(output logic [31:0] s);
        int                    roll;
        longint unsigned       width;
        longint unsigned       pick;
        roll = $urandom_range(99);
        if (sb.range_hi <= sb.range_lo || roll < 15) begin
            s = $urandom;
        end else if (roll < 30) begin
            case ($urandom_range(3))
                0:       s = sb.range_lo;
                1:       s = sb.range_hi;
                2:       s = sb.range_lo - 1;
                default: s = sb.range_hi + 1;
            endcase
        end else begin
            width = unsigned'(longint'(sb.range_hi) - longint'(sb.range_lo)) + 64'd1;
            pick  = {$urandom, $urandom} % width;
            s     = 32'(longint'(sb.range_lo) + longint'(pick));
        end
    endtask

    task automatic run_sequence();
        int          shape;
        int          n_meas;
        int          n_col;
        logic [31:0] base;
        logic [31:0] s;
        shape  = $urandom_range(3);
        base   = $urandom;
        n_meas = $urandom_range((shape == 3) ? 1 : 0, 6);
        n_col  = $urandom_range(1, 12);
        if ($urandom_range(99) < 80) send_item(OP_CLEAR, $urandom);
        repeat (n_meas) begin
            measure_value(shape, base, s);
            send_item(OP_MEASURE, s);
            if ($urandom_range(99) < 8) send_item(OP_UNUSED, $urandom);
        end
        repeat (n_col) begin
            colorize_value(s);
            send_item(OP_COLORIZE, s);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_CLEAR;
        i_sample    = '0;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        hold_req    = 1'b0;
        work_items  = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(OP_COLORIZE, 32'd0);
        send_item(OP_UNUSED, 32'd5);
        send_item(OP_MEASURE, 32'h8000_0000);
        send_item(OP_COLORIZE, 32'h8000_0000);
        send_item(OP_MEASURE, 32'h7FFF_FFFF);
        send_item(OP_COLORIZE, 32'h8000_0000);
        send_item(OP_COLORIZE, 32'h7FFF_FFFF);
        send_item(OP_COLORIZE, 32'd0);
        send_item(OP_COLORIZE, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
        send_item(OP_MEASURE, 32'd0);
        send_item(OP_MEASURE, 32'd1024);
        send_item(OP_COLORIZE, 32'hFFFF_FFFF);
        foreach (edge_k[j]) begin
            send_item(OP_COLORIZE, 32'(edge_k[j]));
        end
        send_item(OP_COLORIZE, 32'd2000);
        send_item(OP_UNUSED, 32'd4096);
        send_item(OP_COLORIZE, 32'd512);

        hold_req = 1'b1;
        while (work_items < 950) run_sequence();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        while (work_items < 1400) run_sequence();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        while (work_items < ITEM_TARGET) run_sequence();
        i_in_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Covered %0d clears, %0d measures, %0d ignored opcodes, %0d pixels checked,",
                 sb.clears, sb.measures, sb.ignored, sb.pixels_checked);
        $display("with empty, degenerate, wide and narrow ranges and one long output hold-off.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("** heatmap_false_color_core: PASSED **");
        end else begin
            $display("** heatmap_false_color_core: FAILED **");
        end
        $finish;
    end

endmodule
